// File: rtl/pressure_temp_compensation_defines.svh
// assertion helpers for the top rtl, sampled on aclk and held off during reset
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("ptc assertion failed");

`endif

// File: rtl/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

    localparam int DIV_BITS = 64;

    localparam logic [1:0] REG_TEMP_CAL   = 2'd0;
    localparam logic [1:0] REG_PRES_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRES_CAL_B = 2'd2;
    localparam logic [1:0] REG_PRES_CAL_C = 2'd3;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic        [31:0] pressure_q24_8;
        logic               pressure_valid;
    } out_t;

    // temperature results and divisor status riding alongside the pressure path
    typedef struct packed {
        logic signed [15:0] centi;
        logic signed [31:0] tf;
        logic               div_ok;
    } side_t;

    // low word of a 64-bit operand times a signed 17-bit factor, exact, sign-extended
    function automatic logic [63:0] mul_lo(input logic [31:0] x, input logic signed [16:0] c);
        logic signed [49:0] p;
        p = $signed({1'b0, x}) * c;
        return {{14{p[49]}}, p};
    endfunction

    // high word contribution, only its low 32 bits survive the 64-bit wrap
    function automatic logic [31:0] mul_hi(input logic [31:0] x, input logic signed [16:0] c);
        logic [31:0] cx;
        cx = {{15{c[16]}}, c};
        return x * cx;
    endfunction

endpackage

// File: rtl/ptc_div.sv
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0] divisor,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [DIV_BITS-1:0] quotient,
    output side_t               out_side
);

    logic [DIV_BITS+1:0] v_reg;
    logic [DIV_BITS-1:0] rem_reg [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] b_reg   [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] aq_reg  [0:DIV_BITS];
    logic                neg_reg [0:DIV_BITS];
    side_t               side_reg [0:DIV_BITS+1];
    logic [DIV_BITS-1:0] q_reg;

    logic [DIV_BITS-1:0] mag_a, mag_b;
    logic [DIV_BITS:0]   trial    [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] rem_next [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] aq_next  [0:DIV_BITS-1];

    assign mag_a = dividend[DIV_BITS-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[DIV_BITS-1]  ? (~divisor + 1'b1)  : divisor;

    // one quotient bit per stage, restoring
    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            trial[k] = {rem_reg[k], aq_reg[k][DIV_BITS-1]} - {1'b0, b_reg[k]};
            if (trial[k][DIV_BITS]) begin
                rem_next[k] = {rem_reg[k][DIV_BITS-2:0], aq_reg[k][DIV_BITS-1]};
            end else begin
                rem_next[k] = trial[k][DIV_BITS-1:0];
            end
            aq_next[k] = {aq_reg[k][DIV_BITS-2:0], ~trial[k][DIV_BITS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_BITS:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            b_reg[0]    <= mag_b;
            aq_reg[0]   <= mag_a;
            neg_reg[0]  <= dividend[DIV_BITS-1] ^ divisor[DIV_BITS-1];
            side_reg[0] <= in_side;
            for (int k = 0; k < DIV_BITS; k++) begin
                if (k < DIV_BITS - 1) begin
                    rem_reg[k+1] <= rem_next[k];
                    b_reg[k+1]   <= b_reg[k];
                end
                aq_reg[k+1]   <= aq_next[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            q_reg <= neg_reg[DIV_BITS] ? (~aq_reg[DIV_BITS] + 1'b1) : aq_reg[DIV_BITS];
            side_reg[DIV_BITS+1] <= side_reg[DIV_BITS];
        end
    end

    assign out_valid = v_reg[DIV_BITS+1];
    assign quotient  = q_reg;
    assign out_side  = side_reg[DIV_BITS+1];

endmodule

// File: rtl/pressure_temp_compensation.sv
// integer compensation of a 20-bit barometric sensor sample
// input channel s_valid/s_ready/s_data carries one raw temperature and one raw
// pressure reading per beat; result channel m_valid/m_ready/m_data returns the
// temperature in hundredths of a degree, the fine temperature, the pressure in
// Pa as unsigned q24.8 and a flag that is clear when the divisor came out zero
// calibration is loaded through cfg_we/cfg_index/cfg_wdata while no beat is in
// flight: index 0 temperature words, 1 to 3 the pressure words
// throughput: one beat per cycle while the receiver keeps taking results
// the 66-stage radix-2 divider (an input stage, 64 stages of one quotient bit
// each, then the sign fix) makes up most of the pipeline, with nine stages of
// multiply and add ahead of it and five behind
// the whole pipeline moves on one enable: while a result waits with m_ready
// low, every stage holds and s_ready is low; nothing is dropped or repeated
// reset (aresetn low, synchronous) empties the pipeline and clears all
// calibration registers to zero
`timescale 1ns / 1ps

module pressure_temp_compensation import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

`include "pressure_temp_compensation_defines.svh"

    logic [47:0] temp_cal_reg;
    logic [63:0] pres_cal_a_reg, pres_cal_b_reg;
    logic [15:0] pres_cal_c_reg;

    logic [15:0]        cal_t1, cal_p1;
    logic signed [15:0] cal_t2, cal_t3;
    logic signed [15:0] cal_p2, cal_p3, cal_p4, cal_p5, cal_p6, cal_p7, cal_p8, cal_p9;

    assign cal_t1 = temp_cal_reg[15:0];
    assign cal_t2 = $signed(temp_cal_reg[31:16]);
    assign cal_t3 = $signed(temp_cal_reg[47:32]);
    assign cal_p1 = pres_cal_a_reg[15:0];
    assign cal_p2 = $signed(pres_cal_a_reg[31:16]);
    assign cal_p3 = $signed(pres_cal_a_reg[47:32]);
    assign cal_p4 = $signed(pres_cal_a_reg[63:48]);
    assign cal_p5 = $signed(pres_cal_b_reg[15:0]);
    assign cal_p6 = $signed(pres_cal_b_reg[31:16]);
    assign cal_p7 = $signed(pres_cal_b_reg[47:32]);
    assign cal_p8 = $signed(pres_cal_b_reg[63:48]);
    assign cal_p9 = $signed(pres_cal_c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg   <= '0;
            pres_cal_a_reg <= '0;
            pres_cal_b_reg <= '0;
            pres_cal_c_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TEMP_CAL:   temp_cal_reg   <= cfg_wdata[47:0];
                REG_PRES_CAL_A: pres_cal_a_reg <= cfg_wdata;
                REG_PRES_CAL_B: pres_cal_b_reg <= cfg_wdata;
                REG_PRES_CAL_C: pres_cal_c_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [8:0] pre_v_reg;
    logic [3:0] post_v_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // temperature path
    logic signed [17:0] s1_a;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_ap, s1_dd;
    logic [31:0]        s1_v1p_reg, s1_dd_reg;
    logic [19:0]        s1_rp_reg;

    assign s1_a  = $signed({1'b0, s_data.raw_temperature[19:3]}) - $signed({1'b0, cal_t1, 1'b0});
    assign s1_d  = $signed({1'b0, s_data.raw_temperature[19:4]}) - $signed({1'b0, cal_t1});
    assign s1_ap = s1_a * cal_t2;
    assign s1_dd = s1_d * s1_d;

    logic signed [19:0] s2_x;
    logic signed [35:0] s2_v2p;
    logic signed [20:0] s2_v1_reg;
    logic [31:0]        s2_v2p_reg;
    logic [19:0]        s2_rp_reg;

    assign s2_x   = $signed(s1_dd_reg[31:12]);
    assign s2_v2p = s2_x * cal_t3;

    logic signed [31:0] s3_tf;
    logic signed [31:0] s3_tf_reg;
    logic [19:0]        s3_rp_reg;

    assign s3_tf = 32'(s2_v1_reg) + 32'($signed(s2_v2p_reg[31:14]));

    logic signed [31:0] s4_tc5, s4_tc;
    logic signed [15:0] s4_centi;
    logic signed [32:0] s4_w1;
    logic signed [32:0] s4_w1_reg;
    side_t              s4_side_reg;
    logic [19:0]        s4_rp_reg;

    always_comb begin
        s4_tc5 = (s3_tf_reg <<< 2) + s3_tf_reg + 32'sd128;
        s4_tc  = s4_tc5 >>> 8;
        if (s4_tc < -32'sd32768) begin
            s4_centi = -16'sd32768;
        end else if (s4_tc > 32'sd32767) begin
            s4_centi = 16'sd32767;
        end else begin
            s4_centi = s4_tc[15:0];
        end
        s4_w1 = 33'(s3_tf_reg) - 33'sd128000;
    end

    // pressure path, 64-bit wrap
    logic signed [32:0] s5_abs;
    logic [31:0]        s5_mag;
    logic [63:0]        s5_sq;
    logic signed [48:0] s5_w1p5, s5_w1p2;
    logic [63:0]        s5_sq_reg;
    logic signed [48:0] s5_w1p5_reg, s5_w1p2_reg;
    side_t              s5_side_reg;
    logic [19:0]        s5_rp_reg;

    assign s5_abs  = s4_w1_reg[32] ? -s4_w1_reg : s4_w1_reg;
    assign s5_mag  = s5_abs[31:0];
    assign s5_sq   = 64'(s5_mag) * 64'(s5_mag);
    assign s5_w1p5 = s4_w1_reg * cal_p5;
    assign s5_w1p2 = s4_w1_reg * cal_p2;

    logic [63:0]        s6_sq6_lo_reg, s6_sq3_lo_reg;
    logic [31:0]        s6_sq6_hi_reg, s6_sq3_hi_reg;
    logic signed [48:0] s6_w1p5_reg, s6_w1p2_reg;
    side_t              s6_side_reg;
    logic [19:0]        s6_rp_reg;

    logic [63:0] s7_sq6, s7_sq3, s7_w2, s7_w1b;
    logic [63:0] s7_w2_reg, s7_w1b_reg;
    side_t       s7_side_reg;
    logic [19:0] s7_rp_reg;

    assign s7_sq6 = s6_sq6_lo_reg + {s6_sq6_hi_reg, 32'd0};
    assign s7_sq3 = s6_sq3_lo_reg + {s6_sq3_hi_reg, 32'd0};
    assign s7_w2  = s7_sq6 + (64'(s6_w1p5_reg) << 17) + (64'(cal_p4) << 35);
    assign s7_w1b = 64'($signed(s7_sq3) >>> 8) + (64'(s6_w1p2_reg) << 12);

    logic [63:0] s8_x1, s8_n0;
    logic [63:0] s8_plo_reg, s8_n0_reg;
    logic [31:0] s8_phi_reg;
    side_t       s8_side_reg;

    assign s8_x1 = s7_w1b_reg + 64'h0000_8000_0000_0000;
    assign s8_n0 = (64'(21'd1048576 - {1'b0, s7_rp_reg}) << 31) - s7_w2_reg;

    logic [63:0] s9_prod, s9_var1, s9_num;
    logic [63:0] s9_var1_reg, s9_num_reg;
    side_t       s9_side_reg;

    assign s9_prod = s8_plo_reg + {s8_phi_reg, 32'd0};
    assign s9_var1 = 64'($signed(s9_prod) >>> 33);
    // times 3125
    assign s9_num  = (s8_n0_reg << 11) + (s8_n0_reg << 10) + (s8_n0_reg << 5)
                   + (s8_n0_reg << 4) + (s8_n0_reg << 2) + s8_n0_reg;

    logic        div_ok;
    logic [63:0] div_divisor, div_q;
    side_t       div_in_side, div_out_side;
    logic        div_out_valid;

    // zero divisor: divide by one to keep the lanes busy, flag carries the outcome
    always_comb begin
        div_ok             = (s9_var1_reg != 64'd0);
        div_divisor        = div_ok ? s9_var1_reg : 64'd1;
        div_in_side        = s9_side_reg;
        div_in_side.div_ok = div_ok;
    end

    ptc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre_v_reg[8]),
        .dividend  (s9_num_reg),
        .divisor   (div_divisor),
        .in_side   (div_in_side),
        .out_valid (div_out_valid),
        .quotient  (div_q),
        .out_side  (div_out_side)
    );

    // post-division corrections
    logic [63:0] q1_s;
    logic [63:0] q1_lolo_reg, q1_p8lo_reg, q1_q_reg;
    logic [31:0] q1_lohi_reg, q1_p8hi_reg;
    side_t       q1_side_reg;

    assign q1_s = 64'($signed(div_q) >>> 13);

    logic [63:0] q2_ss, q2_p8q;
    logic [63:0] q2_ss_reg, q2_p8q_reg, q2_q_reg;
    side_t       q2_side_reg;

    assign q2_ss  = q1_lolo_reg + {q1_lohi_reg[30:0], 1'b0, 32'd0};
    assign q2_p8q = q1_p8lo_reg + {q1_p8hi_reg, 32'd0};

    logic [63:0] q3_p9lo_reg, q3_qu2_reg;
    logic [31:0] q3_p9hi_reg;
    side_t       q3_side_reg;

    logic [63:0] q4_u1p, q4_t;
    logic [63:0] q4_t_reg;
    side_t       q4_side_reg;

    assign q4_u1p = q3_p9lo_reg + {q3_p9hi_reg, 32'd0};
    assign q4_t   = q3_qu2_reg + 64'($signed(q4_u1p) >>> 25);

    logic [63:0] out_pres;

    assign out_pres = 64'($signed(q4_t_reg) >>> 8) + (64'(cal_p7) << 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_v_reg   <= '0;
            post_v_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            pre_v_reg   <= {pre_v_reg[7:0], s_valid};
            post_v_reg  <= {post_v_reg[2:0], div_out_valid};
            m_valid_reg <= post_v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_v1p_reg <= s1_ap[31:0];
            s1_dd_reg  <= s1_dd[31:0];
            s1_rp_reg  <= s_data.raw_pressure;

            s2_v1_reg  <= $signed(s1_v1p_reg[31:11]);
            s2_v2p_reg <= s2_v2p[31:0];
            s2_rp_reg  <= s1_rp_reg;

            s3_tf_reg <= s3_tf;
            s3_rp_reg <= s2_rp_reg;

            s4_w1_reg          <= s4_w1;
            s4_side_reg.centi  <= s4_centi;
            s4_side_reg.tf     <= s3_tf_reg;
            s4_side_reg.div_ok <= 1'b0;
            s4_rp_reg          <= s3_rp_reg;

            s5_sq_reg   <= s5_sq;
            s5_w1p5_reg <= s5_w1p5;
            s5_w1p2_reg <= s5_w1p2;
            s5_side_reg <= s4_side_reg;
            s5_rp_reg   <= s4_rp_reg;

            s6_sq6_lo_reg <= mul_lo(s5_sq_reg[31:0],  {cal_p6[15], cal_p6});
            s6_sq6_hi_reg <= mul_hi(s5_sq_reg[63:32], {cal_p6[15], cal_p6});
            s6_sq3_lo_reg <= mul_lo(s5_sq_reg[31:0],  {cal_p3[15], cal_p3});
            s6_sq3_hi_reg <= mul_hi(s5_sq_reg[63:32], {cal_p3[15], cal_p3});
            s6_w1p5_reg   <= s5_w1p5_reg;
            s6_w1p2_reg   <= s5_w1p2_reg;
            s6_side_reg   <= s5_side_reg;
            s6_rp_reg     <= s5_rp_reg;

            s7_w2_reg   <= s7_w2;
            s7_w1b_reg  <= s7_w1b;
            s7_side_reg <= s6_side_reg;
            s7_rp_reg   <= s6_rp_reg;

            s8_plo_reg  <= mul_lo(s8_x1[31:0],  $signed({1'b0, cal_p1}));
            s8_phi_reg  <= mul_hi(s8_x1[63:32], $signed({1'b0, cal_p1}));
            s8_n0_reg   <= s8_n0;
            s8_side_reg <= s7_side_reg;

            s9_var1_reg <= s9_var1;
            s9_num_reg  <= s9_num;
            s9_side_reg <= s8_side_reg;

            q1_lolo_reg <= 64'(q1_s[31:0]) * 64'(q1_s[31:0]);
            q1_lohi_reg <= q1_s[31:0] * q1_s[63:32];
            q1_p8lo_reg <= mul_lo(div_q[31:0],  {cal_p8[15], cal_p8});
            q1_p8hi_reg <= mul_hi(div_q[63:32], {cal_p8[15], cal_p8});
            q1_q_reg    <= div_q;
            q1_side_reg <= div_out_side;

            q2_ss_reg   <= q2_ss;
            q2_p8q_reg  <= q2_p8q;
            q2_q_reg    <= q1_q_reg;
            q2_side_reg <= q1_side_reg;

            q3_p9lo_reg <= mul_lo(q2_ss_reg[31:0],  {cal_p9[15], cal_p9});
            q3_p9hi_reg <= mul_hi(q2_ss_reg[63:32], {cal_p9[15], cal_p9});
            q3_qu2_reg  <= q2_q_reg + 64'($signed(q2_p8q_reg) >>> 19);
            q3_side_reg <= q2_side_reg;

            q4_t_reg    <= q4_t;
            q4_side_reg <= q3_side_reg;

            m_data_reg.temperature_centi <= q4_side_reg.centi;
            m_data_reg.fine_temperature  <= q4_side_reg.tf;
            m_data_reg.pressure_q24_8    <= q4_side_reg.div_ok ? out_pres[31:0] : 32'd0;
            m_data_reg.pressure_valid    <= q4_side_reg.div_ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PTC_ASSERT_IMP(a_pres_zero, m_valid && !m_data.pressure_valid, m_data.pressure_q24_8 == 32'd0)
    `PTC_ASSERT_IMP(a_stall_holds_input, m_valid && !m_ready, !s_ready)
    `PTC_ASSERT_NXT(a_beat_enters, s_valid && s_ready, pre_v_reg[0])

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ptc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TEMP_CAL;
    logic [63:0] cfg_wdata = '0;

    pressure_temp_compensation uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // calibration copy
    logic [47:0] cal_t;
    logic [63:0] cal_pa, cal_pb;
    logic [15:0] cal_pc;

    in_t  pending_samples[$];
    out_t compensated_due[$];
    int   send_idle = 0;
    int   take_idle = 0;
    int   errors = 0;

    function automatic out_t compensate(in_t x);
        out_t r;
        logic [31:0] t1, t2, t3, a, v1, d, dd, v2, tf, tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, s, u1, u2, num;
        logic [63:0] q, mn, md;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a  = {15'd0, x.raw_temperature[19:3]} - (t1 << 1);
        v1 = $signed(a * t2) >>> 11;
        d  = {16'd0, x.raw_temperature[19:4]} - t1;
        dd = $signed(d * d) >>> 12;
        v2 = $signed(dd * t3) >>> 14;
        tf = v1 + v2;
        tc = $signed(tf * 32'd5 + 32'd128) >>> 8;
        if ($signed(tc) < -32768) r.temperature_centi = -16'sd32768;
        else if ($signed(tc) > 32767) r.temperature_centi = 16'sd32767;
        else r.temperature_centi = tc[15:0];
        r.fine_temperature = tf;
        p1 = {48'd0, cal_pa[15:0]};
        p2 = $signed(cal_pa[31:16]);
        p3 = $signed(cal_pa[47:32]);
        p4 = $signed(cal_pa[63:48]);
        p5 = $signed(cal_pb[15:0]);
        p6 = $signed(cal_pb[31:16]);
        p7 = $signed(cal_pb[47:32]);
        p8 = $signed(cal_pb[63:48]);
        p9 = $signed(cal_pc);
        w1 = $signed(tf) - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        r.pressure_q24_8 = '0;
        r.pressure_valid = 1'b0;
        if (w1 != 0) begin
            p = 64'sd1048576 - $signed({44'd0, x.raw_pressure});
            num = ((p <<< 31) - w2) * 64'sd3125;
            // unsigned magnitudes so the most negative value wraps
            mn = num[63] ? -num : num;
            md = w1[63] ? -w1 : w1;
            q = mn / md;
            p = (num[63] != w1[63]) ? -q : q;
            s = p >>> 13;
            u1 = (p9 * s * s) >>> 25;
            u2 = (p8 * p) >>> 19;
            p = ((p + u1 + u2) >>> 8) + (p7 <<< 4);
            r.pressure_q24_8 = p[31:0];
            r.pressure_valid = 1'b1;
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= take_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_t e;
        if (aresetn) begin
            if (s_valid && s_ready) compensated_due.push_back(compensate(s_data));
            if (m_valid && m_ready) begin
                if (compensated_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = compensated_due.pop_front();
                    if (m_data.temperature_centi !== e.temperature_centi) begin
                        $error("temperature_centi exp %0d got %0d",
                               e.temperature_centi, m_data.temperature_centi);
                        errors++;
                    end
                    if (m_data.fine_temperature !== e.fine_temperature) begin
                        $error("fine_temperature exp %0d got %0d",
                               e.fine_temperature, m_data.fine_temperature);
                        errors++;
                    end
                    if (m_data.pressure_q24_8 !== e.pressure_q24_8) begin
                        $error("pressure_q24_8 exp %h got %h",
                               e.pressure_q24_8, m_data.pressure_q24_8);
                        errors++;
                    end
                    if (m_data.pressure_valid !== e.pressure_valid) begin
                        $error("pressure_valid exp %b got %b",
                               e.pressure_valid, m_data.pressure_valid);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic load_cal_word(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMP_CAL:   cal_t = val[47:0];
            REG_PRES_CAL_A: cal_pa = val;
            REG_PRES_CAL_B: cal_pb = val;
            default:        cal_pc = val[15:0];
        endcase
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || s_valid || compensated_due.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic in_t rand_sample();
        in_t x;
        x.raw_temperature = 20'($urandom_range(20'hFFFFF));
        x.raw_pressure = 20'($urandom_range(20'hFFFFF));
        return x;
    endfunction

    // typical datasheet calibration
    task automatic load_typical;
        load_cal_word(REG_TEMP_CAL, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
        load_cal_word(REG_PRES_CAL_A, {16'd2855, 16'd8192, 16'hD67B, 16'd36477});
        load_cal_word(REG_PRES_CAL_B, {16'hFF3C, 16'h3E4E, 16'hFFF9, 16'd140});
        load_cal_word(REG_PRES_CAL_C, 64'd6000);
    endtask

    task automatic load_random;
        load_cal_word(REG_TEMP_CAL, {$urandom, $urandom});
        load_cal_word(REG_PRES_CAL_A, {$urandom, $urandom});
        load_cal_word(REG_PRES_CAL_B, {$urandom, $urandom});
        load_cal_word(REG_PRES_CAL_C, {32'd0, $urandom});
    endtask

    task automatic run_random(input int n, input bit typical);
        in_t x;
        repeat (n) begin
            x = rand_sample();
            // realistic readings near the nominal operating point
            if (typical && $urandom_range(3) != 0) begin
                x.raw_temperature = 20'(20'd519888 + $urandom_range(60000) - 30000);
                x.raw_pressure = 20'(20'd415148 + $urandom_range(200000) - 100000);
            end
            pending_samples.push_back(x);
        end
        drain();
    endtask

    initial begin
        in_t x;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 15; take_idle = 71;
        // reset calibration: divisor is zero
        x.raw_temperature = 20'd0; x.raw_pressure = 20'd0;
        pending_samples.push_back(x);
        x.raw_temperature = 20'hFFFFF; x.raw_pressure = 20'hFFFFF;
        pending_samples.push_back(x);
        drain();
        load_typical();
        for (int i = 0; i < 20; i++) begin
            x.raw_temperature = 20'd1 << i;
            x.raw_pressure = ~(20'd1 << i);
            pending_samples.push_back(x);
        end
        x.raw_temperature = 20'd519888; x.raw_pressure = 20'd415148;
        pending_samples.push_back(x);
        drain();
        // extremes of the calibration words
        load_cal_word(REG_TEMP_CAL, 64'h0000_FFFF_FFFF_FFFF);
        load_cal_word(REG_PRES_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
        load_cal_word(REG_PRES_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
        load_cal_word(REG_PRES_CAL_C, 64'h0000_0000_0000_FFFF);
        run_random(200, 0);
        load_cal_word(REG_TEMP_CAL, 64'h0000_8000_8000_0000);
        load_cal_word(REG_PRES_CAL_A, 64'h8000_8000_8000_FFFF);
        load_cal_word(REG_PRES_CAL_B, 64'h7FFF_7FFF_8000_7FFF);
        load_cal_word(REG_PRES_CAL_C, 64'h0000_0000_0000_8000);
        run_random(200, 0);
        send_idle = 71; take_idle = 15;
        load_typical();
        run_random(400, 1);
        load_random();
        run_random(200, 0);
        send_idle = 0; take_idle = 0;
        load_typical();
        run_random(400, 1);
        load_random();
        run_random(280, 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && compensated_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_div.sv
rtl/pressure_temp_compensation.sv
tb/testbench.sv
